FILE: rtl/bsq_pkg.sv
// Shared constants, types and codes for the broadcast subscriber queue.
// No dependencies.
`default_nettype none
package bsq_pkg;

	localparam int NUM_SUBS = 16;
	localparam int QDEPTH   = 16;
	localparam int MSG_W    = 32;
	localparam int SID_W    = 4;
	localparam int IDX_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W    = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_PUBLISHED = 3'd0,
		ST_REFUSED   = 3'd1,
		ST_NEW_SUB   = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_DELIVERED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic publish;
		logic fetch;
	} cell_cmd_t;

	typedef struct packed {
		logic             sub;
		logic [CNT_W-1:0] pend;
		logic [IDX_W-1:0] ridx;
	} cell_view_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
		logic [IDX_W-1:0] res;
		if (pos == IDX_W'(QDEPTH - 1))
			res = '0;
		else
			res = pos + 1'b1;
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bsq_cell.sv
// One subscriber cell: subscribed flag, read index and pending count.
// Passes the queue-full flag on to its neighbor, ORed with its own full state. Depends on bsq_pkg.
`default_nettype none
module bsq_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  bsq_pkg::cell_cmd_t    cmd,
	input  wire                         hit,
	input  wire  [bsq_pkg::IDX_W-1:0]   wr_idx,
	input  wire                         full_in,
	output logic                        full_out,
	output bsq_pkg::cell_view_t         view
);
	import bsq_pkg::*;

	logic             sub_q;
	logic [CNT_W-1:0] pend_q;
	logic [IDX_W-1:0] ridx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= 1'b0;
			pend_q <= '0;
			ridx_q <= '0;
		end else if (cmd.publish && sub_q) begin
			pend_q <= pend_q + 1'b1;
		end else if (cmd.fetch && hit) begin
			if (!sub_q) begin
				sub_q  <= 1'b1;
				ridx_q <= wr_idx;
				pend_q <= '0;
			end else if (pend_q != '0) begin
				ridx_q <= ring_next(ridx_q);
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	assign full_out  = full_in | (sub_q && (pend_q == CNT_W'(QDEPTH)));
	assign view.sub  = sub_q;
	assign view.pend = pend_q;
	assign view.ridx = ridx_q;

endmodule
`default_nettype wire

FILE: rtl/bsq_ring.sv
// Shared message ring: one write port, one registered read port.
// Depends on bsq_pkg.
`default_nettype none
module bsq_ring (
	input  wire                        clk,
	input  wire                        we,
	input  wire  [bsq_pkg::IDX_W-1:0]  waddr,
	input  wire  [bsq_pkg::MSG_W-1:0]  wdata,
	input  wire                        re,
	input  wire  [bsq_pkg::IDX_W-1:0]  raddr,
	output logic [bsq_pkg::MSG_W-1:0]  rdata
);
	import bsq_pkg::*;

	logic [MSG_W-1:0] mem [QDEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/broadcast_subscriber_queue_core.sv
// Input fields are registered at accept; one item in flight, and no new item is
// taken until the result is loaded. The ring read is taken at accept, and the
// cell update plus result load happen when the execute state commits.
// A stalled result holds the block in its execute cycle until taken.
// Reset (arst_n low) clears all subscriber cells, the write index and the
// output valid flag; ring contents are undefined until written.
`default_nettype none
module broadcast_subscriber_queue_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        action,
	input  wire  [bsq_pkg::SID_W-1:0]  subscriber_id,
	input  wire  [bsq_pkg::MSG_W-1:0]  message,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [bsq_pkg::MSG_W-1:0]  data,
	output bsq_pkg::status_t           status
);
	import bsq_pkg::*;

	state_t           state_q;
	logic             action_q;
	logic             sid_ok_q;
	logic [MSG_W-1:0] msg_q;
	logic [IDX_W-1:0] wr_idx_q;
	cell_view_t       view_q;
	logic [NUM_SUBS-1:0] hit_q;
	logic             out_valid_q;
	logic [MSG_W-1:0] data_q;
	status_t          status_q;

	cell_view_t       views [NUM_SUBS];
	logic [NUM_SUBS:0] full_c;
	cell_view_t       sel_view;
	logic [NUM_SUBS-1:0] hit_in;
	logic             sid_ok_in;
	logic             accept;
	logic             commit;
	logic             pub_go;
	cell_cmd_t        cmd;
	logic [MSG_W-1:0] ring_rd;
	status_t          res_status;
	logic [MSG_W-1:0] res_data;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		sel_view  = '0;
		sid_ok_in = 1'b0;
		for (int i = 0; i < NUM_SUBS; i++) begin
			hit_in[i] = (32'(subscriber_id) == i);
			if (hit_in[i]) begin
				sel_view  = views[i];
				sid_ok_in = 1'b1;
			end
		end
	end

	assign full_c[0] = 1'b0;
	assign pub_go    = !action_q && !full_c[NUM_SUBS];
	assign cmd.publish = commit && pub_go;
	assign cmd.fetch   = commit && action_q;

	for (genvar g = 0; g < NUM_SUBS; g++) begin : g_cell
		bsq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.hit      (hit_q[g]),
			.wr_idx   (wr_idx_q),
			.full_in  (full_c[g]),
			.full_out (full_c[g+1]),
			.view     (views[g])
		);
	end

	bsq_ring u_ring (
		.clk   (clk),
		.we    (cmd.publish),
		.waddr (wr_idx_q),
		.wdata (msg_q),
		.re    (accept),
		.raddr (sel_view.ridx),
		.rdata (ring_rd)
	);

	always_comb begin
		res_data = '0;
		if (!action_q) begin
			res_status = pub_go ? ST_PUBLISHED : ST_REFUSED;
		end else if (!sid_ok_q) begin
			res_status = ST_EMPTY;
		end else if (!view_q.sub) begin
			res_status = ST_NEW_SUB;
		end else if (view_q.pend == '0) begin
			res_status = ST_EMPTY;
		end else begin
			res_status = ST_DELIVERED;
			res_data   = ring_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (pub_go)
							wr_idx_q <= ring_next(wr_idx_q);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			sid_ok_q <= sid_ok_in;
			msg_q    <= message;
			view_q   <= sel_view;
			hit_q    <= hit_in;
		end
		if (commit) begin
			data_q   <= res_data;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;

endmodule
`default_nettype wire

FILE: rtl/bsq_checker.sv
// Port-level checks for broadcast_subscriber_queue_core, bound into that module.
// Depends on bsq_pkg.
`default_nettype none
module bsq_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	input  wire                        in_ready,
	input  wire                        out_valid,
	input  wire                        out_ready,
	input  wire  [bsq_pkg::MSG_W-1:0]  data,
	input  wire  bsq_pkg::status_t     status
);
	import bsq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DELIVERED |-> data == '0)
		else $error("nonzero data without delivery");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_PUBLISHED || status == ST_REFUSED ||
			status == ST_NEW_SUB || status == ST_EMPTY || status == ST_DELIVERED)
		else $error("bad status code");

endmodule

bind broadcast_subscriber_queue_core bsq_checker u_bsq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data      (data),
	.status    (status)
);
`default_nettype wire

FILE: verif/broadcast_subscriber_queue_core_test.sv
// Self-checking testbench for broadcast_subscriber_queue_core: directed table, then random
// publish/fetch traffic with bursty input and a stalling receiver, checked by a topic predictor.
// Depends on bsq_pkg and the core RTL.
module broadcast_subscriber_queue_core_test;
	import bsq_pkg::*;

	localparam bit ACT_PUBLISH = 1'b0;
	localparam bit ACT_FETCH   = 1'b1;
	localparam int DIR_ROWS    = 25;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 75;
	localparam int LONG_HOLD   = 120;

	typedef struct {
		logic [MSG_W-1:0] data;
		status_t          status;
	} reply_t;

	typedef struct {
		bit               act;
		logic [SID_W-1:0] sid;
		logic [MSG_W-1:0] msg;
		bit               typed;
		reply_t           want;
	} row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                action = 1'b0;
	logic [SID_W-1:0]    subscriber_id = '0;
	logic [MSG_W-1:0]    message = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [MSG_W-1:0]    data;
	status_t             status;

	bit                  sub_on   [NUM_SUBS];
	logic [IDX_W-1:0]    sub_rd   [NUM_SUBS];
	logic [CNT_W-1:0]    sub_pend [NUM_SUBS];
	logic [MSG_W-1:0]    ring     [QDEPTH];
	logic [IDX_W-1:0]    wr_pos;

	reply_t              replies_due[$];
	row_t                dir_rows[DIR_ROWS];
	int                  mismatches = 0;
	int                  burst_left = 0;
	bit                  hold_req = 1'b0;

	broadcast_subscriber_queue_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.subscriber_id (subscriber_id),
		.message       (message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data          (data),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[broadcast_subscriber_queue_core] ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [MSG_W-1:0] want,
			input logic [MSG_W-1:0] got);
		if (mismatches < 50)
			$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
		mismatches++;
	endtask

	function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] pos);
		return IDX_W'((int'(pos) + 1) % QDEPTH);
	endfunction

	function automatic reply_t topic_update(input bit act, input logic [SID_W-1:0] sid,
			input logic [MSG_W-1:0] msg);
		reply_t r;
		bit     full;
		r.data = '0;
		full = 1'b0;
		if (act == ACT_PUBLISH) begin
			for (int i = 0; i < NUM_SUBS; i++)
				if (sub_on[i] && sub_pend[i] >= QDEPTH)
					full = 1'b1;
			if (full) begin
				r.status = ST_REFUSED;
			end else begin
				ring[wr_pos] = msg;
				wr_pos = ring_step(wr_pos);
				for (int i = 0; i < NUM_SUBS; i++)
					if (sub_on[i])
						sub_pend[i] = sub_pend[i] + 1'b1;
				r.status = ST_PUBLISHED;
			end
		end else if (int'(sid) >= NUM_SUBS) begin
			r.status = ST_EMPTY;
		end else if (!sub_on[sid]) begin
			sub_on[sid] = 1'b1;
			sub_rd[sid] = wr_pos;
			sub_pend[sid] = '0;
			r.status = ST_NEW_SUB;
		end else if (sub_pend[sid] == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.data = ring[sub_rd[sid]];
			sub_rd[sid] = ring_step(sub_rd[sid]);
			sub_pend[sid] = sub_pend[sid] - 1'b1;
			r.status = ST_DELIVERED;
		end
		return r;
	endfunction

	function automatic row_t mk_row(input bit act, input logic [SID_W-1:0] sid,
			input logic [MSG_W-1:0] msg, input bit typed, input status_t st,
			input logic [MSG_W-1:0] d);
		row_t w;
		w.act = act;
		w.sid = sid;
		w.msg = msg;
		w.typed = typed;
		w.want.status = st;
		w.want.data = d;
		return w;
	endfunction

	task automatic offer(input bit act, input logic [SID_W-1:0] sid,
			input logic [MSG_W-1:0] msg, input bit typed, input reply_t want);
		reply_t r;
		in_valid <= 1'b1;
		action <= act;
		subscriber_id <= sid;
		message <= msg;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		r = topic_update(act, sid, msg);
		replies_due.push_back(typed ? want : r);
	endtask

	task automatic pace(input bit steady);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = steady ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain(input int cap);
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (replies_due.size() != 0 && n < cap) begin
			@(posedge clk);
			n++;
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (replies_due.size() == 0) begin
				report("result with none due", '0, data);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status)
					report("status", MSG_W'(want.status), MSG_W'(status));
				if (data !== want.data)
					report("data", want.data, data);
			end
		end
	end

	initial begin
		int mode;
		int left;
		int tick;
		mode = 0;
		left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				tick++;
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		reply_t           none;
		bit               act;
		logic [SID_W-1:0] sid;
		logic [MSG_W-1:0] msg;
		int               pub_pct;
		int               base;
		int               span;
		bit               steady;

		none.data = '0;
		none.status = ST_EMPTY;
		for (int i = 0; i < NUM_SUBS; i++) begin
			sub_on[i] = 1'b0;
			sub_rd[i] = '0;
			sub_pend[i] = '0;
		end
		for (int i = 0; i < QDEPTH; i++)
			ring[i] = '0;
		wr_pos = '0;

		dir_rows[0] = mk_row(ACT_PUBLISH, 4'hF, 32'hA5A5_A5A5, 1, ST_PUBLISHED, '0);
		dir_rows[1] = mk_row(ACT_FETCH, 4'hF, 32'h0, 1, ST_NEW_SUB, '0);
		dir_rows[2] = mk_row(ACT_FETCH, 4'hF, 32'hFFFF_FFFF, 1, ST_EMPTY, '0);
		dir_rows[3] = mk_row(ACT_PUBLISH, 4'h0, 32'hFFFF_FFFF, 1, ST_PUBLISHED, '0);
		dir_rows[4] = mk_row(ACT_FETCH, 4'hF, 32'h0, 1, ST_DELIVERED, 32'hFFFF_FFFF);
		dir_rows[5] = mk_row(ACT_FETCH, 4'h0, 32'h0, 1, ST_NEW_SUB, '0);
		for (int i = 6; i < 22; i++)
			dir_rows[i] = mk_row(ACT_PUBLISH, SID_W'($urandom),
				(i == 6) ? 32'h0 : 32'($urandom), 1, ST_PUBLISHED, '0);
		dir_rows[22] = mk_row(ACT_PUBLISH, 4'h5, 32'h5A5A_5A5A, 1, ST_REFUSED, '0);
		dir_rows[23] = mk_row(ACT_FETCH, 4'h0, 32'h0, 1, ST_DELIVERED, '0);
		dir_rows[24] = mk_row(ACT_FETCH, 4'h9, 32'h0, 1, ST_NEW_SUB, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer(dir_rows[i].act, dir_rows[i].sid, dir_rows[i].msg, dir_rows[i].typed,
				dir_rows[i].want);
			pace(1'b0);
		end
		drain(5000);

		for (int ph = 0; ph < PHASES; ph++) begin
			pub_pct = $urandom_range(10, 90);
			base = $urandom_range(0, NUM_SUBS - 1);
			span = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
				: $urandom_range(0, NUM_SUBS - 1);
			steady = (ph % 4 == 0);
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				act = ($urandom_range(1, 100) <= pub_pct) ? ACT_PUBLISH : ACT_FETCH;
				sid = SID_W'((base + $urandom_range(0, span)) % NUM_SUBS);
				case ($urandom_range(0, 7))
				0: msg = '0;
				1: msg = '1;
				default: msg = $urandom;
				endcase
				offer(act, sid, msg, 1'b0, none);
				pace(steady || (ph == 3 && k < 20));
			end
			if (ph % 3 == 2)
				drain(5000);
		end

		drain(5000);
		repeat (10) @(posedge clk);
		if (replies_due.size() != 0)
			report("results never delivered", '0, MSG_W'(replies_due.size()));
		if (mismatches == 0)
			$display("[broadcast_subscriber_queue_core] OK");
		else
			$display("[broadcast_subscriber_queue_core] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/bsq_pkg.sv
rtl/bsq_cell.sv
rtl/bsq_ring.sv
rtl/broadcast_subscriber_queue_core.sv
rtl/bsq_checker.sv
verif/broadcast_subscriber_queue_core_test.sv
